### hdl/octc_pkg.sv
package octc_pkg;

  // Register field width and result ring mask width
  localparam int CFG_W  = 16;
  localparam int MASK_W = 12;

  // Default build parameters
  localparam int RING_LEDS_DEF = 12;
  localparam int ARC_LEN_DEF   = 4;
  localparam int KNOB_BITS_DEF = 10;

  // Phase codes
  localparam logic [1:0] PH_WAIT  = 2'd0;
  localparam logic [1:0] PH_RUN   = 2'd1;
  localparam logic [1:0] PH_PAUSE = 2'd2;
  localparam logic [1:0] PH_FIN   = 2'd3;

  // Ring colour codes
  localparam logic [1:0] COL_OFF    = 2'd0;
  localparam logic [1:0] COL_BLUE   = 2'd1;
  localparam logic [1:0] COL_GREEN  = 2'd2;
  localparam logic [1:0] COL_YELLOW = 2'd3;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_MIN_COOK    = 3'd0;
  localparam logic [2:0] REG_MAX_COOK    = 3'd1;
  localparam logic [2:0] REG_DEBOUNCE    = 3'd2;
  localparam logic [2:0] REG_FINISH_HOLD = 3'd3;
  localparam logic [2:0] REG_FLASH_HALF  = 3'd4;
  localparam logic [2:0] REG_SPIN_STEP   = 3'd5;

  // Register reset values
  localparam logic [CFG_W-1:0] MIN_COOK_RST    = 16'd500;
  localparam logic [CFG_W-1:0] MAX_COOK_RST    = 16'd5000;
  localparam logic [CFG_W-1:0] DEBOUNCE_RST    = 16'd200;
  localparam logic [CFG_W-1:0] FINISH_HOLD_RST = 16'd4000;
  localparam logic [CFG_W-1:0] FLASH_HALF_RST  = 16'd500;
  localparam logic [CFG_W-1:0] SPIN_STEP_RST   = 16'd100;

  // Button and door levels travelling down the pipeline
  typedef struct packed {
    logic start_pause;
    logic stop;
    logic door_closed;
  } octc_btn_t;

  // Saturating millisecond counter step
  function automatic logic [CFG_W-1:0] sat_inc(input logic [CFG_W-1:0] v);
    return (v == {CFG_W{1'b1}}) ? v : v + {{(CFG_W-1){1'b0}}, 1'b1};
  endfunction

endpackage

### hdl/octc_cook_scale.sv
module octc_cook_scale import octc_pkg::*; #(
  parameter int KNOB_BITS = KNOB_BITS_DEF
) (
  input  logic [CFG_W+KNOB_BITS-1:0] prod,
  input  logic                       neg,
  input  logic [CFG_W-1:0]           min_cook,
  output logic [CFG_W-1:0]           cook
);

  localparam int R_W = CFG_W + 2;
  localparam logic [R_W-1:0] FULL = R_W'((1 << KNOB_BITS) - 1);

  logic [CFG_W-1:0] q1;
  logic [R_W-1:0]   r1, q2, r2, q3, r3, qsum;
  logic [CFG_W-1:0] quot;

  // Divide by 2^n-1: fold the high part back onto the low part three times
  always_comb begin
    q1   = CFG_W'(prod >> KNOB_BITS);
    r1   = R_W'(prod[KNOB_BITS-1:0]) + R_W'(q1);
    q2   = r1 >> KNOB_BITS;
    r2   = R_W'(r1[KNOB_BITS-1:0]) + q2;
    q3   = r2 >> KNOB_BITS;
    r3   = R_W'(r2[KNOB_BITS-1:0]) + q3;
    qsum = R_W'(q1) + q2 + q3 + R_W'(r3 >= FULL);
    quot = qsum[CFG_W-1:0];
  end

  // Apply the scale direction, quotient truncated toward zero
  assign cook = neg ? (min_cook - quot) : (min_cook + quot);

endmodule

### hdl/octc_ring_arc.sv
module octc_ring_arc import octc_pkg::*; #(
  parameter int RING_LEDS = RING_LEDS_DEF,
  parameter int ARC_LEN   = ARC_LEN_DEF
) (
  input  logic [$clog2(RING_LEDS)-1:0] pos,
  output logic [RING_LEDS-1:0]         arc
);

  logic [RING_LEDS-1:0]   base;
  logic [2*RING_LEDS-1:0] dbl;

  // Build the arc at position zero, then rotate it round the ring
  always_comb begin
    for (int i = 0; i < RING_LEDS; i++) begin
      base[i] = (i < ARC_LEN);
    end
    dbl = {base, base} << pos;
    arc = dbl[2*RING_LEDS-1:RING_LEDS];
  end

endmodule

### hdl/oven_cook_timer_controller_core.sv
// Oven cook timer controller. Each request on the in_ channel is one millisecond tick
// carrying the start/pause and stop button levels, the door switch and the knob sample;
// each tick yields exactly one result on the out_ channel (relay drive, phase, ring LED
// mask and colour, time left). A new tick is taken every cycle unless in_stall is high. Each
// tick passes the cook time pipeline (capture, knob multiply, then division by the knob full
// scale), then the phase logic and the result register. Registers lie at
// byte address 4*i: 0 min cook, 1 max cook, 2 debounce, 3 finish hold, 4 flash half
// period, 5 spin step, all 16 bits in milliseconds; write them only while idle.
module oven_cook_timer_controller_core import octc_pkg::*; #(
  parameter int RING_LEDS = RING_LEDS_DEF,
  parameter int ARC_LEN   = ARC_LEN_DEF,
  parameter int KNOB_BITS = KNOB_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_start_pause_level,
  input  logic                 in_stop_level,
  input  logic                 in_door_closed,
  input  logic [KNOB_BITS-1:0] in_knob_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_relay_on,
  output logic [1:0]           out_phase_code,
  output logic [MASK_W-1:0]    out_ring_mask,
  output logic [1:0]           out_ring_colour,
  output logic [CFG_W-1:0]     out_time_left_ms,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int SPIN_W = $clog2(RING_LEDS);
  localparam int PROD_W = CFG_W + KNOB_BITS;

  // Configuration registers
  logic [CFG_W-1:0] min_cook_r, max_cook_r, debounce_r, hold_r, flash_half_r, spin_step_r;

  // Pipeline registers
  logic                 s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  octc_btn_t            s1_btn_r, s2_btn_r, s3_btn_r;
  logic [KNOB_BITS-1:0] s1_knob_r;
  logic [PROD_W-1:0]    s2_prod_r;
  logic                 s2_neg_r;
  logic [CFG_W-1:0]     s3_cook_r;

  // Controller state
  logic [1:0]           phase_r, prev_phase_r;
  logic [CFG_W-1:0]     budget_r, phase_clk_r, light_clk_r, deb_clk_r;
  logic [SPIN_W-1:0]    spin_pos_r;
  logic                 flash_on_r, start_lat_r, stop_lat_r, door_lat_r;
  logic [RING_LEDS-1:0] lit_pat_r;
  logic [1:0]           lit_col_r;

  logic [1:0]           phase_nxt;
  logic [CFG_W-1:0]     budget_nxt, phase_clk_nxt, light_clk_nxt, deb_clk_nxt;
  logic [SPIN_W-1:0]    spin_pos_nxt;
  logic                 flash_on_nxt, start_lat_nxt, stop_lat_nxt, door_lat_nxt;
  logic [RING_LEDS-1:0] lit_pat_nxt;
  logic [1:0]           lit_col_nxt;
  logic                 relay_nxt;

  // Output registers
  logic                 out_relay_r;
  logic [1:0]           out_phase_r, out_col_r;
  logic [MASK_W-1:0]    out_mask_r;
  logic [CFG_W-1:0]     out_time_r;

  logic                 out_free, free1, free2, free3, mv1, mv2, mv3, in_take;
  logic                 start_press, stop_press, do_flash;
  logic [1:0]           flash_col;
  logic [CFG_W:0]       diff;
  logic [CFG_W-1:0]     diff_mag, cook;
  logic [RING_LEDS-1:0] arc;
  logic                 cfg_wr;

  // Pipeline flow: a stage moves when the one after it is empty or moving
  assign out_free = !out_valid_r || !out_stall;
  assign mv3      = s3_valid_r && out_free;
  assign free3    = !s3_valid_r || mv3;
  assign mv2      = s2_valid_r && free3;
  assign free2    = !s2_valid_r || mv2;
  assign mv1      = s1_valid_r && free2;
  assign free1    = !s1_valid_r || mv1;
  assign in_stall = !free1;
  assign in_take  = in_valid && free1;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_cook_r   <= MIN_COOK_RST;
      max_cook_r   <= MAX_COOK_RST;
      debounce_r   <= DEBOUNCE_RST;
      hold_r       <= FINISH_HOLD_RST;
      flash_half_r <= FLASH_HALF_RST;
      spin_step_r  <= SPIN_STEP_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_MIN_COOK:    min_cook_r   <= pwdata[CFG_W-1:0];
        REG_MAX_COOK:    max_cook_r   <= pwdata[CFG_W-1:0];
        REG_DEBOUNCE:    debounce_r   <= pwdata[CFG_W-1:0];
        REG_FINISH_HOLD: hold_r       <= pwdata[CFG_W-1:0];
        REG_FLASH_HALF:  flash_half_r <= pwdata[CFG_W-1:0];
        REG_SPIN_STEP:   spin_step_r  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (paddr[4:2])
      REG_MIN_COOK:    prdata = 32'(min_cook_r);
      REG_MAX_COOK:    prdata = 32'(max_cook_r);
      REG_DEBOUNCE:    prdata = 32'(debounce_r);
      REG_FINISH_HOLD: prdata = 32'(hold_r);
      REG_FLASH_HALF:  prdata = 32'(flash_half_r);
      REG_SPIN_STEP:   prdata = 32'(spin_step_r);
      default:         prdata = 32'd0;
    endcase
  end

  // Stage 1: capture the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (free1) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_btn_r  <= '{start_pause: in_start_pause_level, stop: in_stop_level,
                     door_closed: in_door_closed};
      s1_knob_r <= in_knob_value;
    end
  end

  // Stage 2: scale span magnitude by the knob
  assign diff     = {1'b0, max_cook_r} - {1'b0, min_cook_r};
  assign diff_mag = diff[CFG_W] ? CFG_W'(~diff + 1'b1) : diff[CFG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (free2) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mv1) begin
      s2_btn_r  <= s1_btn_r;
      s2_prod_r <= PROD_W'(diff_mag) * PROD_W'(s1_knob_r);
      s2_neg_r  <= diff[CFG_W];
    end
  end

  // Stage 3: divide by full scale and add the minimum
  octc_cook_scale #(
    .KNOB_BITS(KNOB_BITS)
  ) u_scale (
    .prod     (s2_prod_r),
    .neg      (s2_neg_r),
    .min_cook (min_cook_r),
    .cook     (cook)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (free3) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mv2) begin
      s3_btn_r  <= s2_btn_r;
      s3_cook_r <= cook;
    end
  end

  // Arc at the current spin position
  octc_ring_arc #(
    .RING_LEDS(RING_LEDS),
    .ARC_LEN  (ARC_LEN)
  ) u_arc (
    .pos (spin_pos_r),
    .arc (arc)
  );

  // Phase logic for one tick
  always_comb begin
    // debounce and edge detect
    deb_clk_nxt   = sat_inc(deb_clk_r);
    start_lat_nxt = start_lat_r;
    stop_lat_nxt  = stop_lat_r;
    door_lat_nxt  = door_lat_r;
    start_press   = 1'b0;
    stop_press    = 1'b0;
    if (deb_clk_nxt >= debounce_r &&
        (s3_btn_r.start_pause != start_lat_r || s3_btn_r.stop != stop_lat_r ||
         s3_btn_r.door_closed != door_lat_r)) begin
      start_press   = s3_btn_r.start_pause && !start_lat_r;
      stop_press    = s3_btn_r.stop && !stop_lat_r;
      start_lat_nxt = s3_btn_r.start_pause;
      stop_lat_nxt  = s3_btn_r.stop;
      door_lat_nxt  = s3_btn_r.door_closed;
      deb_clk_nxt   = '0;
    end

    phase_nxt     = phase_r;
    budget_nxt    = budget_r;
    phase_clk_nxt = phase_clk_r;
    light_clk_nxt = light_clk_r;
    spin_pos_nxt  = spin_pos_r;
    flash_on_nxt  = flash_on_r;
    lit_pat_nxt   = lit_pat_r;
    lit_col_nxt   = lit_col_r;
    relay_nxt     = 1'b0;
    do_flash      = 1'b0;
    flash_col     = COL_GREEN;

    // entry work on the first tick of a phase
    if (phase_r != prev_phase_r) begin
      case (phase_r)
        PH_WAIT: begin
          lit_pat_nxt = '0;
          lit_col_nxt = COL_OFF;
          budget_nxt  = '0;
        end
        PH_RUN: begin
          light_clk_nxt = '0;
        end
        PH_PAUSE: begin
          lit_pat_nxt   = '0;
          lit_col_nxt   = COL_OFF;
          flash_on_nxt  = 1'b0;
          light_clk_nxt = '0;
        end
        default: begin
          lit_pat_nxt   = '0;
          lit_col_nxt   = COL_OFF;
          flash_on_nxt  = 1'b0;
          light_clk_nxt = '0;
          phase_clk_nxt = '0;
        end
      endcase
    end

    case (phase_r)
      PH_WAIT: begin
        if (start_press && door_lat_nxt) begin
          budget_nxt = s3_cook_r;
          phase_nxt  = PH_RUN;
        end
      end
      PH_RUN: begin
        if (!door_lat_nxt || (budget_nxt != '0 && start_press)) begin
          phase_nxt = PH_PAUSE;
        end else if (budget_nxt == '0) begin
          phase_nxt = PH_FIN;
        end else if (stop_press) begin
          phase_nxt = PH_WAIT;
        end else begin
          relay_nxt  = 1'b1;
          budget_nxt = budget_nxt - 1'b1;
          if (light_clk_nxt == '0) begin
            lit_pat_nxt  = arc;
            lit_col_nxt  = COL_BLUE;
            spin_pos_nxt = (spin_pos_r == SPIN_W'(RING_LEDS - 1)) ? '0 : spin_pos_r + 1'b1;
          end
          light_clk_nxt = sat_inc(light_clk_nxt);
          if (light_clk_nxt >= spin_step_r) begin
            light_clk_nxt = '0;
          end
        end
      end
      PH_PAUSE: begin
        if (start_press) begin
          phase_nxt = PH_RUN;
        end else if (stop_press) begin
          phase_nxt = PH_WAIT;
        end else begin
          do_flash  = 1'b1;
          flash_col = COL_GREEN;
        end
      end
      default: begin
        phase_clk_nxt = sat_inc(phase_clk_nxt);
        if (!door_lat_nxt || phase_clk_nxt >= hold_r) begin
          phase_nxt = PH_WAIT;
        end else begin
          do_flash  = 1'b1;
          flash_col = COL_YELLOW;
        end
      end
    endcase

    // toggle the flash once each half period
    if (do_flash) begin
      light_clk_nxt = sat_inc(light_clk_nxt);
      if (light_clk_nxt >= flash_half_r) begin
        light_clk_nxt = '0;
        flash_on_nxt  = !flash_on_nxt;
        if (flash_on_nxt) begin
          lit_pat_nxt = {RING_LEDS{1'b1}};
          lit_col_nxt = flash_col;
        end else begin
          lit_pat_nxt = '0;
          lit_col_nxt = COL_OFF;
        end
      end
    end
  end

  // Advance the state as each request leaves stage 3
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_WAIT;
      prev_phase_r <= PH_PAUSE;
      budget_r     <= '0;
      phase_clk_r  <= '0;
      light_clk_r  <= '0;
      deb_clk_r    <= '0;
      spin_pos_r   <= '0;
      flash_on_r   <= 1'b0;
      start_lat_r  <= 1'b0;
      stop_lat_r   <= 1'b0;
      door_lat_r   <= 1'b0;
      lit_pat_r    <= '0;
      lit_col_r    <= COL_OFF;
    end else if (mv3) begin
      phase_r      <= phase_nxt;
      prev_phase_r <= phase_r;
      budget_r     <= budget_nxt;
      phase_clk_r  <= phase_clk_nxt;
      light_clk_r  <= light_clk_nxt;
      deb_clk_r    <= deb_clk_nxt;
      spin_pos_r   <= spin_pos_nxt;
      flash_on_r   <= flash_on_nxt;
      start_lat_r  <= start_lat_nxt;
      stop_lat_r   <= stop_lat_nxt;
      door_lat_r   <= door_lat_nxt;
      lit_pat_r    <= lit_pat_nxt;
      lit_col_r    <= lit_col_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mv3) begin
      out_relay_r <= relay_nxt;
      out_phase_r <= phase_nxt;
      out_mask_r  <= MASK_W'(lit_pat_nxt);
      out_col_r   <= lit_col_nxt;
      out_time_r  <= budget_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_relay_on     = out_relay_r;
  assign out_phase_code   = out_phase_r;
  assign out_ring_mask    = out_mask_r;
  assign out_ring_colour  = out_col_r;
  assign out_time_left_ms = out_time_r;

endmodule

### hdl/octc_checker.sv
module octc_checker import octc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_relay_on,
  input logic [1:0]        out_phase_code,
  input logic [MASK_W-1:0] out_ring_mask,
  input logic [1:0]        out_ring_colour,
  input logic [CFG_W-1:0]  out_time_left_ms
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_relay_on) &&
      $stable(out_phase_code) && $stable(out_ring_mask) &&
      $stable(out_ring_colour) && $stable(out_time_left_ms))
    else $error("stalled result changed");

  // Drive the relay only while running
  a_relay_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_relay_on |-> out_phase_code == PH_RUN)
    else $error("relay on outside running phase");

  // Finish only with the time used up
  a_fin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_phase_code == PH_FIN |-> out_time_left_ms == '0)
    else $error("time left in finished phase");

  // Take requests whenever the result register is empty
  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

endmodule

bind oven_cook_timer_controller_core octc_checker u_octc_checker (.*);

### tb/tb_oven_cook_timer_controller_core.sv
`timescale 1ns / 1ps

module tb_oven_cook_timer_controller_core;
  import octc_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 11;
  localparam int LIMIT_CYCLES   = 400000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 5;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_REPORTS    = 10;
  localparam int KNOB_W         = KNOB_BITS_DEF;
  localparam longint KNOB_FULL  = (longint'(1) << KNOB_W) - 1;

  // Indexes beyond the register map, written to prove they are ignored
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  typedef struct packed {
    logic              start_pause;
    logic              stop;
    logic              door_closed;
    logic [KNOB_W-1:0] knob;
  } tick_req_t;

  typedef struct packed {
    logic              relay_on;
    logic [1:0]        phase_code;
    logic [MASK_W-1:0] ring_mask;
    logic [1:0]        ring_colour;
    logic [CFG_W-1:0]  time_left_ms;
  } panel_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_start_pause_level;
  logic              in_stop_level;
  logic              in_door_closed;
  logic [KNOB_W-1:0] in_knob_value;
  logic              out_valid;
  logic              out_stall;
  logic              out_relay_on;
  logic [1:0]        out_phase_code;
  logic [MASK_W-1:0] out_ring_mask;
  logic [1:0]        out_ring_colour;
  logic [CFG_W-1:0]  out_time_left_ms;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [4:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  oven_cook_timer_controller_core uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_start_pause_level (in_start_pause_level),
    .in_stop_level        (in_stop_level),
    .in_door_closed       (in_door_closed),
    .in_knob_value        (in_knob_value),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_relay_on         (out_relay_on),
    .out_phase_code       (out_phase_code),
    .out_ring_mask        (out_ring_mask),
    .out_ring_colour      (out_ring_colour),
    .out_time_left_ms     (out_time_left_ms),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Register mirror
  logic [CFG_W-1:0] cfg_min      = MIN_COOK_RST;
  logic [CFG_W-1:0] cfg_max      = MAX_COOK_RST;
  logic [CFG_W-1:0] cfg_debounce = DEBOUNCE_RST;
  logic [CFG_W-1:0] cfg_hold     = FINISH_HOLD_RST;
  logic [CFG_W-1:0] cfg_flash    = FLASH_HALF_RST;
  logic [CFG_W-1:0] cfg_spin     = SPIN_STEP_RST;

  // Controller state as it stands after reset
  logic [1:0]        ph        = PH_WAIT;
  logic [1:0]        prev_ph   = PH_PAUSE;
  logic [CFG_W-1:0]  budget    = '0;
  logic [CFG_W-1:0]  phase_clk = '0;
  logic [CFG_W-1:0]  light_clk = '0;
  logic [CFG_W-1:0]  deb_clk   = '0;
  int                spin_pos  = 0;
  logic              flash_on  = 1'b0;
  logic              start_l   = 1'b0;
  logic              stop_l    = 1'b0;
  logic              door_l    = 1'b0;
  logic [MASK_W-1:0] lit_pat   = '0;
  logic [1:0]        lit_col   = COL_OFF;

  tick_req_t   tick_backlog[$];
  panel_t      panel_due[$];
  int          ticks_queued;
  int          ticks_taken;
  int          results_checked;
  int          mismatch_count;
  int          settings_applied;
  int          backpressure_cycles;
  int          cycle_count;
  logic [3:0]  phase_seen;
  logic        in_fire;
  int          burst_left;
  int          gap_left;
  int          mode_left;
  int          holdoff_left;
  logic        holdoff_arm;
  stall_mode_t stall_mode;
  logic        lvl_sp;
  logic        lvl_st;
  logic        lvl_dc;
  panel_t      seen;
  panel_t      want;

  function automatic logic [CFG_W-1:0] bump(input logic [CFG_W-1:0] v);
    return (v == {CFG_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  // Count a mismatch and say whether it is still worth printing
  function automatic bit report_slot();
    mismatch_count++;
    return mismatch_count <= MAX_REPORTS;
  endfunction

  // Toggle the flash every flash half period, full ring in the given colour
  function automatic void flash_step(input logic [1:0] colour);
    light_clk = bump(light_clk);
    if (light_clk >= cfg_flash) begin
      light_clk = '0;
      flash_on  = ~flash_on;
      if (flash_on) begin
        lit_pat = '1;
        lit_col = colour;
      end else begin
        lit_pat = '0;
        lit_col = COL_OFF;
      end
    end
  endfunction

  // Advance the controller by one millisecond tick and return its panel outputs
  function automatic panel_t advance_oven(input logic sp, input logic st, input logic dc,
                                          input logic [KNOB_W-1:0] knob);
    panel_t     r;
    logic [1:0] was;
    logic       start_hit;
    logic       stop_hit;
    logic       relay;
    longint     span;
    int         i;
    was       = ph;
    start_hit = 1'b0;
    stop_hit  = 1'b0;
    relay     = 1'b0;

    // Sample the inputs once the debounce window has passed
    deb_clk = bump(deb_clk);
    if (deb_clk >= cfg_debounce) begin
      if (sp != start_l || st != stop_l || dc != door_l) begin
        start_hit = sp & ~start_l;
        stop_hit  = st & ~stop_l;
        start_l   = sp;
        stop_l    = st;
        door_l    = dc;
        deb_clk   = '0;
      end
    end

    // Entry work on the first tick of a new phase
    if (ph != prev_ph) begin
      case (ph)
        PH_WAIT: begin
          lit_pat = '0;
          lit_col = COL_OFF;
          budget  = '0;
        end
        PH_RUN: begin
          light_clk = '0;
        end
        PH_PAUSE: begin
          lit_pat   = '0;
          lit_col   = COL_OFF;
          flash_on  = 1'b0;
          light_clk = '0;
        end
        default: begin
          lit_pat   = '0;
          lit_col   = COL_OFF;
          flash_on  = 1'b0;
          light_clk = '0;
          phase_clk = '0;
        end
      endcase
    end

    case (ph)
      PH_WAIT: begin
        if (start_hit && door_l) begin
          span   = longint'(cfg_max) - longint'(cfg_min);
          budget = CFG_W'(longint'(cfg_min) + span * longint'(knob) / KNOB_FULL);
          ph     = PH_RUN;
        end
      end
      PH_RUN: begin
        if (!door_l || (budget != 0 && start_hit)) begin
          ph = PH_PAUSE;
        end else if (budget == 0) begin
          ph = PH_FIN;
        end else if (stop_hit) begin
          ph = PH_WAIT;
        end else begin
          relay  = 1'b1;
          budget = budget - 1'b1;
          // Draw the arc and step it round the ring
          if (light_clk == 0) begin
            lit_pat = '0;
            for (i = 0; i < ARC_LEN_DEF; i++)
              lit_pat[(spin_pos + i) % RING_LEDS_DEF] = 1'b1;
            lit_col  = COL_BLUE;
            spin_pos = (spin_pos + 1) % RING_LEDS_DEF;
          end
          light_clk = bump(light_clk);
          if (light_clk >= cfg_spin) light_clk = '0;
        end
      end
      PH_PAUSE: begin
        if (start_hit) ph = PH_RUN;
        else if (stop_hit) ph = PH_WAIT;
        else flash_step(COL_GREEN);
      end
      default: begin
        phase_clk = bump(phase_clk);
        if (!door_l || phase_clk >= cfg_hold) ph = PH_WAIT;
        else flash_step(COL_YELLOW);
      end
    endcase
    prev_ph = was;

    r.relay_on     = relay;
    r.phase_code   = ph;
    r.ring_mask    = lit_pat;
    r.ring_colour  = lit_col;
    r.time_left_ms = budget;
    return r;
  endfunction

  // Drive requests from the backlog in bursts with gaps between them
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (tick_backlog.size() > 0) begin
        tick_req_t tk;
        tk = tick_backlog.pop_front();
        in_valid             <= 1'b1;
        in_start_pause_level <= tk.start_pause;
        in_stop_level        <= tk.stop;
        in_door_closed       <= tk.door_closed;
        in_knob_value        <= tk.knob;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result channel on a changing pattern, with one long hold-off on request
  always @(negedge clk) begin
    if (holdoff_arm && holdoff_left == 0) begin
      holdoff_left = HOLDOFF_CYCLES;
      holdoff_arm  = 1'b0;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= (mode_left % 3 == 0);
      endcase
    end
  end

  // Predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && in_stall) backpressure_cycles++;
    if (rst_n && in_valid && !in_stall) begin
      want = advance_oven(in_start_pause_level, in_stop_level, in_door_closed, in_knob_value);
      phase_seen[want.phase_code] = 1'b1;
      panel_due.push_back(want);
      ticks_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin
      seen = '{out_relay_on, out_phase_code, out_ring_mask, out_ring_colour, out_time_left_ms};
      if (panel_due.size() == 0) begin
        if (report_slot())
          $display("%0t: result with nothing expected: relay=%0d phase=%0d mask=%h colour=%0d left=%0d",
                   $time, seen.relay_on, seen.phase_code, seen.ring_mask, seen.ring_colour,
                   seen.time_left_ms);
      end else begin
        want = panel_due.pop_front();
        results_checked++;
        if (seen.relay_on !== want.relay_on || seen.phase_code !== want.phase_code ||
            seen.ring_mask !== want.ring_mask || seen.ring_colour !== want.ring_colour ||
            seen.time_left_ms !== want.time_left_ms) begin
          if (report_slot()) begin
            $display("%0t: result %0d expected relay=%0d phase=%0d mask=%h colour=%0d left=%0d",
                     $time, results_checked, want.relay_on, want.phase_code, want.ring_mask,
                     want.ring_colour, want.time_left_ms);
            $display("%0t: result %0d actual   relay=%0d phase=%0d mask=%h colour=%0d left=%0d",
                     $time, results_checked, seen.relay_on, seen.phase_code, seen.ring_mask,
                     seen.ring_colour, seen.time_left_ms);
          end
        end
      end
    end
  end

  // Abandon the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Write one register, update the mirror and read it back
  task automatic reg_write(input logic [2:0] idx, input logic [CFG_W-1:0] val);
    logic [31:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_MIN_COOK:    cfg_min      = val;
      REG_MAX_COOK:    cfg_max      = val;
      REG_DEBOUNCE:    cfg_debounce = val;
      REG_FINISH_HOLD: cfg_hold     = val;
      REG_FLASH_HALF:  cfg_flash    = val;
      REG_SPIN_STEP:   cfg_spin     = val;
      default: ;
    endcase
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx <= REG_SPIN_STEP && got[CFG_W-1:0] !== val) begin
      if (report_slot())
        $display("%0t: register %0d read back %h, expected %h", $time, idx, got[CFG_W-1:0], val);
    end
  endtask

  task automatic apply_setting(input int min_ms, input int max_ms, input int deb_ms,
                               input int hold_ms, input int flash_ms, input int spin_ms);
    reg_write(REG_MIN_COOK, CFG_W'(min_ms));
    reg_write(REG_MAX_COOK, CFG_W'(max_ms));
    reg_write(REG_DEBOUNCE, CFG_W'(deb_ms));
    reg_write(REG_FINISH_HOLD, CFG_W'(hold_ms));
    reg_write(REG_FLASH_HALF, CFG_W'(flash_ms));
    reg_write(REG_SPIN_STEP, CFG_W'(spin_ms));
    settings_applied++;
    @(posedge clk);
  endtask

  // Wait until no request is pending and every result has been checked
  task automatic settle();
    while (tick_backlog.size() != 0 || in_valid || panel_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_tick(input logic sp, input logic st, input logic dc,
                           input logic [KNOB_W-1:0] knob);
    tick_backlog.push_back(tick_req_t'{sp, st, dc, knob});
    ticks_queued++;
  endtask

  // Hold the current levels for n ticks with a random knob
  task automatic add_ticks(input int n);
    for (int k = 0; k < n; k++) push_tick(lvl_sp, lvl_st, lvl_dc, KNOB_W'($urandom));
  endtask

  // Hold length around the debounce window, so some changes land inside it
  function automatic int press_span();
    int cap;
    cap = (cfg_debounce > 8) ? 8 : int'(cfg_debounce);
    return $urandom_range(1, cap + 3);
  endfunction

  // Queue button sessions with random timing, plus some noise
  task automatic run_random(input int n);
    int goal;
    int pick;
    goal = ticks_queued + n;
    while (ticks_queued < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        lvl_sp = 1'b1;
        add_ticks(press_span());
        lvl_sp = 1'b0;
        add_ticks(press_span());
      end else if (pick < 50) begin
        lvl_st = 1'b1;
        add_ticks(press_span());
        lvl_st = 1'b0;
        add_ticks(press_span());
      end else if (pick < 65) begin
        lvl_dc = ~lvl_dc;
        add_ticks(press_span());
        if (!lvl_dc && $urandom_range(0, 9) < 7) begin
          lvl_dc = 1'b1;
          add_ticks(press_span());
        end
      end else if (pick < 85) begin
        add_ticks($urandom_range(5, 60));
      end else begin
        repeat ($urandom_range(1, 6))
          push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), KNOB_W'($urandom));
        lvl_sp = 1'b0;
        lvl_st = 1'b0;
        lvl_dc = 1'b1;
        add_ticks(press_span());
      end
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    in_valid             = 1'b0;
    in_start_pause_level = 1'b0;
    in_stop_level        = 1'b0;
    in_door_closed       = 1'b0;
    in_knob_value        = '0;
    out_stall            = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_fire              = 1'b0;
    burst_left           = 0;
    gap_left             = 0;
    mode_left            = 0;
    holdoff_left         = 0;
    holdoff_arm          = 1'b0;
    stall_mode           = STALL_NONE;
    lvl_sp               = 1'b0;
    lvl_st               = 1'b0;
    lvl_dc               = 1'b1;
    ticks_queued         = 0;
    ticks_taken          = 0;
    results_checked      = 0;
    mismatch_count       = 0;
    settings_applied     = 0;
    backpressure_cycles  = 0;
    cycle_count          = 0;
    phase_seen           = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk);

    // Directed: no debounce, so every level change acts on the tick that carries it
    apply_setting(2, 65535, 0, 3, 0, 0);
    push_tick(1, 0, 0, 100);    // start with the door open is ignored
    push_tick(0, 0, 1, 0);
    push_tick(1, 0, 1, 0);      // start at knob zero: minimum cook time
    push_tick(0, 0, 1, 1023);
    push_tick(0, 0, 1, 0);
    push_tick(0, 0, 1, 0);      // time used up
    repeat (4) push_tick(0, 0, 1, 0);  // flash yellow until the hold time ends
    push_tick(1, 0, 1, 1023);   // start at full scale: maximum cook time
    push_tick(0, 0, 1, 0);
    push_tick(1, 0, 1, 0);      // pause by a second press
    push_tick(0, 0, 1, 0);
    push_tick(1, 0, 1, 0);      // resume
    push_tick(0, 0, 0, 0);      // door opens while running
    push_tick(0, 1, 1, 0);      // stop from paused
    push_tick(1, 1, 1, 512);    // start and stop together from waiting
    push_tick(0, 0, 1, 0);
    push_tick(0, 1, 1, 0);      // stop while running
    push_tick(1, 0, 1, 0);
    repeat (3) push_tick(0, 0, 1, 0);
    push_tick(0, 0, 0, 0);      // door opens while finished
    settle();

    apply_setting(5, 40, 0, 20, 1, 1);
    run_random(120);
    settle();

    // Maximum below minimum: the scale runs downward; zero hold leaves finished at once
    apply_setting(60, 5, 2, 0, 3, 3);
    run_random(110);
    settle();

    apply_setting(0, 0, 1, 65535, 65535, 65535);
    run_random(100);
    settle();

    apply_setting(65535, 0, 3, 10, 2, 5);
    reg_write(REG_SPARE_LO, 16'h0001);
    reg_write(REG_SPARE_HI, 16'hFFFF);
    run_random(100);
    settle();

    // Debounce window longer than the run: inputs never latch
    apply_setting(10, 30, 65535, 25, 4, 2);
    run_random(40);
    settle();

    // Hold off the receiver while requests keep coming, so the input stalls
    apply_setting(1, 20, 4, 15, 4, 2);
    run_random(140);
    @(posedge clk);
    holdoff_arm = 1'b1;
    settle();

    apply_setting(8, 50, 1, 30, 5, 4);
    run_random(120);
    settle();

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d ticks over %0d register settings, %0d results checked, phases seen %b.",
             ticks_taken, settings_applied, results_checked, phase_seen);
    $display("Summary: one %0d-cycle receiver hold-off; input stalled on %0d cycles.",
             HOLDOFF_CYCLES, backpressure_cycles);
    if (mismatch_count == 0 && panel_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
